// File: rtl/core/sstf_pkg.sv
`timescale 1ns / 1ps

package sstf_pkg;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_SEL_BIT   = 2;

    localparam logic REG_AGE_THRESHOLD = 1'b0;
    localparam logic REG_START_HEAD    = 1'b1;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_SERVE = 1'b1;

    localparam logic [7:0]  THRESHOLD_RESET = 8'd3;
    localparam logic [15:0] HEAD_RESET      = 16'd50;

    typedef enum logic [1:0] {
        ST_SERVED = 2'd0,
        ST_ADDED  = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef struct packed {
        logic        action;
        logic [15:0] track;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] served_track;
        logic [15:0] seek_distance;
        logic [31:0] total_seek;
        logic        served_by_aging;
        logic [4:0]  pending_count;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_AGE,
        S_DIST,
        S_DRAIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic issue_age;
        logic issue_dist;
    } scan_ctrl_t;

    typedef struct packed {
        logic       idle;
        logic       finish;
        scan_ctrl_t scan;
    } seq_t;

endpackage

// File: rtl/core/sstf_ram.sv
`timescale 1ns / 1ps

module sstf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/sstf_ctrl.sv
`timescale 1ns / 1ps

module sstf_ctrl #(
    parameter int MAX_REQUESTS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_accept,
    input  logic                            action,
    input  logic                            count_zero,
    input  logic                            count_full,
    input  logic                            pend_at_cnt,
    input  logic                            out_free,
    output sstf_pkg::seq_t                  seq,
    output logic [$clog2(MAX_REQUESTS)-1:0] cnt
);

    import sstf_pkg::*;

    localparam int IDXW = $clog2(MAX_REQUESTS);
    localparam logic [IDXW-1:0] LAST = IDXW'(MAX_REQUESTS - 1);

    state_t          state_reg, state_next;
    logic [IDXW-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (req_accept)
                begin
                    if (action == ACT_ADD)
                    begin
                        state_next = count_full ? S_DONE : S_FIND;
                    end
                    else
                    begin
                        state_next = count_zero ? S_DONE : S_AGE;
                    end
                end
            end
            S_FIND:
            begin
                if (!pend_at_cnt || cnt_reg == LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_AGE:
            begin
                if (cnt_reg == LAST)
                begin
                    state_next = S_DIST;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DIST:
            begin
                if (cnt_reg == LAST)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        seq.idle            = (state_reg == S_IDLE);
        seq.finish          = (state_reg == S_DONE) && out_free;
        seq.scan.clear      = (state_reg == S_IDLE);
        seq.scan.issue_age  = (state_reg == S_AGE);
        seq.scan.issue_dist = (state_reg == S_DIST);
    end

    assign cnt = cnt_reg;

endmodule

// File: rtl/core/sstf_scan.sv
`timescale 1ns / 1ps

module sstf_scan #(
    parameter int MAX_REQUESTS = 16,
    parameter int TRACK_BITS   = 16,
    parameter int AGE_BITS     = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sstf_pkg::scan_ctrl_t            ctrl,
    input  logic [$clog2(MAX_REQUESTS)-1:0] idx,
    input  logic [MAX_REQUESTS-1:0]         pending,
    input  logic [7:0]                      threshold,
    input  logic [TRACK_BITS-1:0]           head,
    input  logic [TRACK_BITS-1:0]           track_rdata,
    input  logic [AGE_BITS-1:0]             age_rdata,
    output logic                            age_we,
    output logic [$clog2(MAX_REQUESTS)-1:0] age_waddr,
    output logic [AGE_BITS-1:0]             age_wdata,
    output logic                            aged,
    output logic [TRACK_BITS-1:0]           best,
    output logic [$clog2(MAX_REQUESTS)-1:0] pick,
    output logic [TRACK_BITS-1:0]           pick_track
);

    import sstf_pkg::*;

    localparam int IDXW = $clog2(MAX_REQUESTS);
    localparam int CMPW = AGE_BITS + 8;

    logic                  p_age_reg;
    logic                  p_dist_reg;
    logic [IDXW-1:0]       p_idx_reg;
    logic                  aged_reg, aged_next;
    logic                  found_reg, found_next;
    logic [AGE_BITS-1:0]   oldest_reg, oldest_next;
    logic [TRACK_BITS-1:0] best_reg, best_next;
    logic [IDXW-1:0]       pick_reg, pick_next;
    logic [TRACK_BITS-1:0] pick_track_reg, pick_track_next;

    logic                  pend;
    logic                  age_due;
    logic                  candidate;
    logic [TRACK_BITS-1:0] gap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_age_reg  <= 1'b0;
            p_dist_reg <= 1'b0;
            aged_reg   <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            p_age_reg  <= ctrl.issue_age;
            p_dist_reg <= ctrl.issue_dist;
            aged_reg   <= aged_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_idx_reg      <= idx;
        oldest_reg     <= oldest_next;
        best_reg       <= best_next;
        pick_reg       <= pick_next;
        pick_track_reg <= pick_track_next;
    end

    // The one shared unit: a magnitude compare and subtract per slot and cycle.
    assign gap = (track_rdata >= head) ? (track_rdata - head) : (head - track_rdata);

    assign pend      = pending[p_idx_reg];
    assign age_due   = CMPW'(age_rdata) >= CMPW'(threshold);
    assign candidate = pend && (!aged_reg || age_rdata == oldest_reg);

    always_comb
    begin
        aged_next       = aged_reg;
        found_next      = found_reg;
        oldest_next     = oldest_reg;
        best_next       = best_reg;
        pick_next       = pick_reg;
        pick_track_next = pick_track_reg;
        if (ctrl.clear)
        begin
            aged_next  = 1'b0;
            found_next = 1'b0;
        end
        else if (p_age_reg)
        begin
            if (pend && age_due)
            begin
                aged_next = 1'b1;
                if (!aged_reg || age_rdata > oldest_reg)
                begin
                    oldest_next = age_rdata;
                end
            end
        end
        else if (p_dist_reg)
        begin
            if (candidate && (!found_reg || gap <= best_reg))
            begin
                found_next      = 1'b1;
                best_next       = gap;
                pick_next       = p_idx_reg;
                pick_track_next = track_rdata;
            end
        end
    end

    // Every pending slot that is not saturated ages in the distance pass; the
    // served slot's age is dropped with it, since an add writes a fresh age.
    assign age_we     = p_dist_reg && pend && !(&age_rdata);
    assign age_waddr  = p_idx_reg;
    assign age_wdata  = age_rdata + 1'b1;

    assign aged       = aged_reg;
    assign best       = best_reg;
    assign pick       = pick_reg;
    assign pick_track = pick_track_reg;

endmodule

// File: rtl/core/sstf_disk_scheduler_with_aging.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_t (action, track)
// rsp       out        rsp_valid/rsp_stall  rsp_t (status ... pending_count)
// apb       in         psel/penable/pready  age_threshold at 0x0, start_head at 0x4
//
// A serve makes one pass over the slots for the greatest age and one for the nearest track,
// one slot per cycle through the read port of the age and track memories, then the drain
// and done states. An add first searches up from slot 0 for the lowest free slot;
// a full add or an empty serve goes straight to its result. Reset clears the pending
// flags and the seek total and sets the head to HEAD_RESET at once; there is no
// clearing pass. A result stalled at rsp holds the block in its last step.

module sstf_disk_scheduler_with_aging #(
    parameter int MAX_REQUESTS = 16,
    parameter int TRACK_BITS   = 16,
    parameter int AGE_BITS     = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  sstf_pkg::req_t                     req,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output sstf_pkg::rsp_t                     rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sstf_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [sstf_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [sstf_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready
);

    import sstf_pkg::*;

    localparam int IDXW = $clog2(MAX_REQUESTS);
    localparam int CW   = $clog2(MAX_REQUESTS + 1);

    seq_t                  seq;
    logic [IDXW-1:0]       cnt;
    logic                  req_accept;
    logic                  cfg_write;
    logic                  out_free;

    logic [7:0]            thr_reg, thr_next;
    logic [TRACK_BITS-1:0] start_head_reg, start_head_next;
    logic [TRACK_BITS-1:0] head_reg, head_next;
    logic [31:0]           total_reg, total_next;
    logic [MAX_REQUESTS-1:0] pending_reg, pending_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;
    rsp_t                  out_reg, out_next;
    logic                  op_reg;
    logic [TRACK_BITS-1:0] trk_reg;

    logic                  count_zero;
    logic                  count_full;
    logic                  is_add;
    logic                  add_ok;
    logic                  served;

    logic [TRACK_BITS-1:0] track_rdata;
    logic [AGE_BITS-1:0]   age_rdata;
    logic                  scan_age_we;
    logic [IDXW-1:0]       scan_age_waddr;
    logic [AGE_BITS-1:0]   scan_age_wdata;
    logic                  age_we;
    logic [IDXW-1:0]       age_waddr;
    logic [AGE_BITS-1:0]   age_wdata;
    logic                  aged;
    logic [TRACK_BITS-1:0] best;
    logic [IDXW-1:0]       pick;
    logic [TRACK_BITS-1:0] pick_track;

    assign req_stall  = !seq.idle;
    assign req_accept = req_valid && !req_stall;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign out_free   = !out_valid_reg || !rsp_stall;
    assign pready     = 1'b1;

    assign count_zero = (count_reg == '0);
    assign count_full = (count_reg == CW'(MAX_REQUESTS));
    assign is_add     = (op_reg == ACT_ADD);
    assign add_ok     = is_add && !count_full;
    assign served     = !is_add && !count_zero;

    sstf_ctrl #(
        .MAX_REQUESTS (MAX_REQUESTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_accept  (req_accept),
        .action      (req.action),
        .count_zero  (count_zero),
        .count_full  (count_full),
        .pend_at_cnt (pending_reg[cnt]),
        .out_free    (out_free),
        .seq         (seq),
        .cnt         (cnt)
    );

    sstf_ram #(
        .WIDTH (TRACK_BITS),
        .DEPTH (MAX_REQUESTS)
    ) u_track_ram (
        .clk   (clk),
        .we    (seq.finish && add_ok),
        .waddr (cnt),
        .wdata (trk_reg),
        .raddr (cnt),
        .rdata (track_rdata)
    );

    assign age_we    = (seq.finish && add_ok) || scan_age_we;
    assign age_waddr = seq.finish ? cnt : scan_age_waddr;
    assign age_wdata = seq.finish ? '0 : scan_age_wdata;

    sstf_ram #(
        .WIDTH (AGE_BITS),
        .DEPTH (MAX_REQUESTS)
    ) u_age_ram (
        .clk   (clk),
        .we    (age_we),
        .waddr (age_waddr),
        .wdata (age_wdata),
        .raddr (cnt),
        .rdata (age_rdata)
    );

    sstf_scan #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .TRACK_BITS   (TRACK_BITS),
        .AGE_BITS     (AGE_BITS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (seq.scan),
        .idx         (cnt),
        .pending     (pending_reg),
        .threshold   (thr_reg),
        .head        (head_reg),
        .track_rdata (track_rdata),
        .age_rdata   (age_rdata),
        .age_we      (scan_age_we),
        .age_waddr   (scan_age_waddr),
        .age_wdata   (scan_age_wdata),
        .aged        (aged),
        .best        (best),
        .pick        (pick),
        .pick_track  (pick_track)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= THRESHOLD_RESET;
            start_head_reg <= TRACK_BITS'(HEAD_RESET);
            head_reg       <= TRACK_BITS'(HEAD_RESET);
            total_reg      <= '0;
            pending_reg    <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            thr_reg        <= thr_next;
            start_head_reg <= start_head_next;
            head_reg       <= head_next;
            total_reg      <= total_next;
            pending_reg    <= pending_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (req_accept)
        begin
            op_reg  <= req.action;
            trk_reg <= TRACK_BITS'(req.track);
        end
    end

    always_comb
    begin
        thr_next        = thr_reg;
        start_head_next = start_head_reg;
        head_next       = head_reg;
        total_next      = total_reg;
        pending_next    = pending_reg;
        count_next      = count_reg;
        if (cfg_write)
        begin
            if (paddr[REG_SEL_BIT] == REG_START_HEAD)
            begin
                start_head_next = TRACK_BITS'(pwdata[15:0]);
                head_next       = TRACK_BITS'(pwdata[15:0]);
            end
            else
            begin
                thr_next = pwdata[7:0];
            end
        end
        if (seq.finish)
        begin
            if (add_ok)
            begin
                pending_next[cnt] = 1'b1;
                count_next        = count_reg + 1'b1;
            end
            else if (served)
            begin
                pending_next[pick] = 1'b0;
                count_next         = count_reg - 1'b1;
                head_next          = pick_track;
                total_next         = total_reg + 32'(best);
            end
        end
    end

    always_comb
    begin
        out_next                 = out_reg;
        out_valid_next           = out_valid_reg && rsp_stall;
        if (seq.finish)
        begin
            out_valid_next           = 1'b1;
            out_next.served_track    = 16'(head_reg);
            out_next.seek_distance   = '0;
            out_next.total_seek      = total_reg;
            out_next.served_by_aging = 1'b0;
            out_next.pending_count   = 5'(count_reg);
            if (is_add)
            begin
                out_next.status = count_full ? ST_FULL : ST_ADDED;
                if (!count_full)
                begin
                    out_next.pending_count = 5'(count_reg + 1'b1);
                end
            end
            else if (count_zero)
            begin
                out_next.status = ST_EMPTY;
            end
            else
            begin
                out_next.status          = ST_SERVED;
                out_next.served_track    = 16'(pick_track);
                out_next.seek_distance   = 16'(best);
                out_next.total_seek      = total_reg + 32'(best);
                out_next.served_by_aging = aged;
                out_next.pending_count   = 5'(count_reg - 1'b1);
            end
        end
    end

    always_comb
    begin
        if (paddr[REG_SEL_BIT] == REG_START_HEAD)
        begin
            prdata = APB_DATA_BITS'(start_head_reg);
        end
        else
        begin
            prdata = APB_DATA_BITS'(thr_reg);
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// File: rtl/core/sstf_checker.sv
`timescale 1ns / 1ps

module sstf_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input sstf_pkg::rsp_t rsp
);

    import sstf_pkg::*;

    // The block works on one transaction at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while a transaction was in progress");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    a_no_seek_unless_served: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_SERVED |-> rsp.seek_distance == '0
            && !rsp.served_by_aging)
        else $error("seek reported without a service");

    a_empty_means_none: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |-> rsp.pending_count == '0)
        else $error("empty status with requests pending");

endmodule

bind sstf_disk_scheduler_with_aging sstf_checker u_sstf_checker (.*);

// File: test/sstf_disk_scheduler_with_aging_test.sv
`timescale 1ns / 1ps

module sstf_disk_scheduler_with_aging_test;
    import sstf_pkg::*;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     req_valid = 1'b0;
    logic                     req_stall;
    req_t                     req = '0;
    logic                     rsp_valid;
    logic                     rsp_stall = 1'b0;
    rsp_t                     rsp;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    sstf_disk_scheduler_with_aging u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    localparam int SLOTS = 16;

    // Scheduler state as the testbench sees it.
    logic [15:0] slot_track [SLOTS];
    logic        slot_busy [SLOTS];
    logic [7:0]  slot_age [SLOTS];
    logic [15:0] head_pos;
    logic [31:0] seek_sum;
    logic [7:0]  age_limit;

    req_t request_q [$];
    rsp_t predicted_rsp_q [$];
    int   results_due = 0;
    int   mismatches = 0;
    int   req_gap = 0;
    int   stall_gap = 0;
    int   idle_odds = 4;
    logic req_fire = 1'b0;
    logic [15:0] track_base = 16'd50;

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("** sstf_disk_scheduler_with_aging: FAILED **");
        $finish;
    end

    function automatic int busy_count();
        int n;
        n = 0;
        for (int s = 0; s < SLOTS; s++)
            if (slot_busy[s])
                n++;
        return n;
    endfunction

    function automatic rsp_t schedule_step(input req_t item);
        rsp_t        r;
        int          slot;
        int          pick;
        logic        aged;
        logic [7:0]  oldest;
        logic [15:0] best;
        logic [15:0] gap;
        r = '0;
        r.served_track = head_pos;
        if (item.action == ACT_ADD) begin
            slot = -1;
            for (int s = 0; s < SLOTS; s++)
                if (!slot_busy[s] && slot < 0)
                    slot = s;
            if (slot < 0) begin
                r.status = ST_FULL;
            end
            else begin
                slot_track[slot] = item.track;
                slot_age[slot] = 8'd0;
                slot_busy[slot] = 1'b1;
                r.status = ST_ADDED;
            end
        end
        else if (busy_count() == 0) begin
            r.status = ST_EMPTY;
        end
        else begin
            aged = 1'b0;
            oldest = 8'd0;
            for (int s = 0; s < SLOTS; s++) begin
                if (slot_busy[s] && slot_age[s] >= age_limit) begin
                    if (!aged || slot_age[s] > oldest)
                        oldest = slot_age[s];
                    aged = 1'b1;
                end
            end
            pick = -1;
            best = 16'd0;
            for (int s = 0; s < SLOTS; s++) begin
                if (slot_busy[s] && !(aged && slot_age[s] != oldest)) begin
                    gap = (slot_track[s] >= head_pos) ? slot_track[s] - head_pos
                                                      : head_pos - slot_track[s];
                    if (pick < 0 || gap <= best) begin
                        best = gap;
                        pick = s;
                    end
                end
            end
            seek_sum = seek_sum + {16'd0, best};
            head_pos = slot_track[pick];
            slot_busy[pick] = 1'b0;
            for (int s = 0; s < SLOTS; s++)
                if (slot_busy[s] && slot_age[s] != 8'hFF)
                    slot_age[s] = slot_age[s] + 8'd1;
            r.status = ST_SERVED;
            r.served_track = head_pos;
            r.seek_distance = best;
            r.served_by_aging = aged;
        end
        r.total_seek = seek_sum;
        r.pending_count = 5'(busy_count());
        return r;
    endfunction

    task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        mismatches++;
    endtask

    // Request sampling and response checking.
    always @(posedge clk) begin : rsp_check
        rsp_t want;
        req_fire = rst_n && req_valid && !req_stall;
        if (req_fire)
            predicted_rsp_q = {predicted_rsp_q, schedule_step(req)};
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (predicted_rsp_q.size() == 0) begin
                $display("%0t: unexpected transaction, expected none actual status %0d",
                         $time, rsp.status);
                mismatches++;
            end
            else begin
                want = predicted_rsp_q.pop_front();
                results_due--;
                if (rsp.status !== want.status)
                    report("status", 32'(want.status), 32'(rsp.status));
                if (rsp.served_track !== want.served_track)
                    report("served_track", 32'(want.served_track), 32'(rsp.served_track));
                if (rsp.seek_distance !== want.seek_distance)
                    report("seek_distance", 32'(want.seek_distance), 32'(rsp.seek_distance));
                if (rsp.total_seek !== want.total_seek)
                    report("total_seek", want.total_seek, rsp.total_seek);
                if (rsp.served_by_aging !== want.served_by_aging)
                    report("served_by_aging", 32'(want.served_by_aging),
                           32'(rsp.served_by_aging));
                if (rsp.pending_count !== want.pending_count)
                    report("pending_count", 32'(want.pending_count), 32'(rsp.pending_count));
            end
        end
    end

    always @(negedge clk) begin : req_driver
        logic next_valid;
        req_t next_req;
        next_valid = req_valid;
        next_req = req;
        if (rst_n && (!req_valid || req_fire)) begin
            next_valid = 1'b0;
            if (req_gap > 0) begin
                req_gap--;
            end
            else if (request_q.size() > 0) begin
                next_valid = 1'b1;
                next_req = request_q.pop_front();
                if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                    req_gap = $urandom_range(1, 13);
            end
        end
        req_valid <= next_valid;
        req <= next_req;
    end

    always @(negedge clk) begin
        if (stall_gap > 0) begin
            rsp_stall <= 1'b1;
            stall_gap--;
        end
        else begin
            rsp_stall <= 1'b0;
            if (idle_odds != 0 && $urandom_range(1, idle_odds * 3) == 1)
                stall_gap = $urandom_range(1, 13);
        end
    end

    task automatic reg_write(input logic idx, input logic [31:0] value);
        logic [APB_ADDR_BITS-1:0] addr;
        addr = '0;
        addr[REG_SEL_BIT] = idx;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_AGE_THRESHOLD) begin
            age_limit = value[7:0];
        end
        else begin
            head_pos = value[15:0];
            track_base = value[15:0];
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send(input logic act, input logic [15:0] trk);
        req_t item;
        item.action = act;
        item.track = trk;
        request_q = {request_q, item};
        results_due++;
    endtask

    task automatic wait_idle();
        while (results_due != 0 || request_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_track();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3: return track_base + 16'($urandom_range(0, 31));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(input logic [7:0] limit, input logic [15:0] start, input int odds);
        int add_pct;
        wait_idle();
        reg_write(REG_AGE_THRESHOLD, {24'd0, limit});
        reg_write(REG_START_HEAD, {16'd0, start});
        idle_odds = odds;
        for (int b = 0; b < 4; b++) begin
            add_pct = $urandom_range(30, 80);
            for (int i = 0; i < 25; i++) begin
                if ($urandom_range(0, 99) < add_pct)
                    send(ACT_ADD, pick_track());
                else
                    send(ACT_SERVE, 16'($urandom));
            end
        end
    endtask

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            slot_track[s] = 16'd0;
            slot_busy[s] = 1'b0;
            slot_age[s] = 8'd0;
        end
        head_pos = HEAD_RESET;
        seek_sum = 32'd0;
        age_limit = THRESHOLD_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send(ACT_SERVE, 16'hFFFF);
        send(ACT_ADD, 16'd0);
        send(ACT_ADD, 16'hFFFF);
        send(ACT_SERVE, 16'd0);
        send(ACT_SERVE, 16'hA5A5);
        send(ACT_ADD, 16'd100);
        send(ACT_ADD, 16'd100);
        for (int i = 0; i < 14; i++)
            send(ACT_ADD, 16'($urandom));
        send(ACT_ADD, 16'h5A5A);
        send(ACT_SERVE, 16'd0);

        random_phase(8'd0, 16'd0, 3);
        random_phase(8'd1, 16'hFFFF, 0);

        // Two far requests age side by side until both saturate.
        wait_idle();
        reg_write(REG_AGE_THRESHOLD, 32'd255);
        reg_write(REG_START_HEAD, 32'd0);
        idle_odds = 6;
        send(ACT_ADD, 16'hFFFF);
        send(ACT_ADD, 16'hFFFE);
        for (int i = 0; i < 258; i++) begin
            send(ACT_ADD, 16'($urandom_range(0, 255)));
            send(ACT_SERVE, 16'($urandom));
        end
        for (int i = 0; i < 3; i++)
            send(ACT_SERVE, 16'($urandom));

        random_phase(8'($urandom_range(1, 8)), 16'($urandom), 4);
        random_phase(8'($urandom_range(1, 255)), 16'($urandom), 10);
        random_phase(8'($urandom_range(2, 5)), 16'($urandom), 2);
        random_phase(THRESHOLD_RESET, HEAD_RESET, 0);

        wait_idle();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && predicted_rsp_q.size() == 0)
            $display("** sstf_disk_scheduler_with_aging: PASSED **");
        else
            $display("** sstf_disk_scheduler_with_aging: FAILED **");
        $finish;
    end

endmodule
